// File: rtl/hclf_pkg.sv
// Shared types and codes of the client lifecycle supervisor.
// Used by every module of the block; depends on nothing else.
package hclf_pkg;

	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_CONNECT_TIMEOUT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RESPONSE_TIMEOUT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RESPONSE_LIMIT = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AUTOSTART = 2'd3;

	localparam logic [15:0] RST_CONNECT_TIMEOUT = 16'd5;
	localparam logic [15:0] RST_RESPONSE_TIMEOUT = 16'd5;
	localparam logic [15:0] RST_RESPONSE_LIMIT = 16'd4096;
	localparam logic RST_AUTOSTART = 1'b1;

	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_CONNECTED = 3'd1;
	localparam logic [2:0] CMD_RECEIVE = 3'd2;
	localparam logic [2:0] CMD_ERROR = 3'd3;
	localparam logic [2:0] CMD_START = 3'd4;
	localparam logic [2:0] CMD_STOP = 3'd5;

	localparam logic [1:0] TMO_NONE = 2'd0;
	localparam logic [1:0] TMO_CONNECT = 2'd1;
	localparam logic [1:0] TMO_RESPONSE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_CONNECTING = 3'd1,
		ST_CONNECTED = 3'd2,
		ST_CLOSING = 3'd3,
		ST_CLOSED = 3'd4,
		ST_DOWN = 3'd5
	} lc_state_t;

	typedef struct packed {
		logic [15:0] connect_timeout;
		logic [15:0] response_timeout;
		logic [15:0] response_limit;
		logic autostart;
	} cfg_t;

	typedef struct packed {
		logic [2:0] command;
		logic session_up;
		logic teardown;
		logic connect_ok;
		logic [15:0] rx_len;
		logic response_complete;
		logic signed [7:0] error_code;
	} in_item_t;

	typedef struct packed {
		logic [2:0] client_state;
		logic open_connection;
		logic send_request;
		logic release_connection;
		logic [15:0] accepted_bytes;
		logic buffer_full;
		logic [1:0] timeout_kind;
		logic error_valid;
		logic signed [7:0] error_held;
	} out_item_t;

endpackage

// File: rtl/hclf_cfg_regs.sv
// Configuration registers of the lifecycle supervisor.
// Depends on hclf_pkg for the register indexes and reset values.
module hclf_cfg_regs
	import hclf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_timeout <= RST_CONNECT_TIMEOUT;
			cfg_q.response_timeout <= RST_RESPONSE_TIMEOUT;
			cfg_q.response_limit <= RST_RESPONSE_LIMIT;
			cfg_q.autostart <= RST_AUTOSTART;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONNECT_TIMEOUT: cfg_q.connect_timeout <= cfg_data;
				CFG_RESPONSE_TIMEOUT: cfg_q.response_timeout <= cfg_data;
				CFG_RESPONSE_LIMIT: cfg_q.response_limit <= cfg_data;
				CFG_AUTOSTART: cfg_q.autostart <= cfg_data[0];
				default: ;	// drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/hclf_next.sv
// Next-state and result logic for one event of the lifecycle supervisor.
// Purely combinational; depends on hclf_pkg for types and codes.
module hclf_next
	import hclf_pkg::*;
#(
	parameter int TIMER_BITS = 16,
	parameter int COUNT_BITS = 16
) (
	input  cfg_t cfg,
	input  in_item_t item,
	input  lc_state_t state_cur,
	input  logic [TIMER_BITS-1:0] timer_cur,
	input  logic [COUNT_BITS-1:0] count_cur,
	input  logic err_flag_cur,
	input  logic signed [7:0] err_code_cur,
	output lc_state_t state_nxt,
	output logic [TIMER_BITS-1:0] timer_nxt,
	output logic [COUNT_BITS-1:0] count_nxt,
	output logic err_flag_nxt,
	output logic signed [7:0] err_code_nxt,
	output out_item_t result
);

	localparam int SUM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
	localparam logic [SUM_W-1:0] CMAX = {{(SUM_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

	function automatic lc_state_t close_active(lc_state_t s);
		return (s == ST_CONNECTING || s == ST_CONNECTED) ? ST_CLOSING : s;
	endfunction

	// receive path: cap the count at the smaller of the limit and the counter range
	logic [SUM_W-1:0] cnt_ext, len_ext, lim_ext, cap_ext, sum_ext, take_ext;
	logic rx_over;

	always_comb begin
		cnt_ext = SUM_W'(count_cur);
		len_ext = SUM_W'(item.rx_len);
		lim_ext = SUM_W'(cfg.response_limit);
		cap_ext = (lim_ext > CMAX) ? CMAX : lim_ext;
		sum_ext = cnt_ext + len_ext;
		rx_over = sum_ext > cap_ext;
		if (rx_over) begin
			take_ext = (cap_ext > cnt_ext) ? (cap_ext - cnt_ext) : '0;
		end else begin
			take_ext = len_ext;
		end
	end

	lc_state_t st;
	logic [TIMER_BITS-1:0] tmr;
	logic tick_done;
	logic open_c, send_c, rel_c, full_c;
	logic [1:0] tk_c;
	logic [15:0] acc_c;

	always_comb begin
		st = state_cur;
		tmr = timer_cur;
		count_nxt = count_cur;
		err_flag_nxt = err_flag_cur;
		err_code_nxt = err_code_cur;
		tick_done = 1'b0;
		open_c = 1'b0;
		send_c = 1'b0;
		rel_c = 1'b0;
		full_c = 1'b0;
		tk_c = TMO_NONE;
		acc_c = '0;

		case (item.command)
			CMD_TICK: begin
				// session rules first
				if (item.session_up) begin
					if (st == ST_DOWN) begin
						st = cfg.autostart ? ST_IDLE : ST_CLOSED;
					end
				end else if (st == ST_DOWN) begin
					tick_done = 1'b1;
				end else if (st == ST_IDLE || st == ST_CLOSED) begin
					st = ST_DOWN;
					tick_done = 1'b1;
				end else begin
					st = close_active(st);
				end

				if (!tick_done) begin
					if (item.teardown) begin
						st = (st == ST_IDLE) ? ST_CLOSED : close_active(st);
					end
					case (st)
						ST_IDLE: begin
							open_c = 1'b1;
							if (item.connect_ok) begin
								st = ST_CONNECTING;
								tmr = TIMER_BITS'(cfg.connect_timeout);
							end
						end
						ST_CONNECTING, ST_CONNECTED: begin
							if (tmr != '0) begin
								tmr = tmr - TIMER_BITS'(1);
							end
							if (tmr == '0) begin
								rel_c = 1'b1;
								if (st == ST_CONNECTING) begin
									tk_c = TMO_CONNECT;
									st = ST_IDLE;
								end else begin
									tk_c = TMO_RESPONSE;
									st = item.session_up ? ST_CLOSED : ST_DOWN;
								end
							end
						end
						ST_CLOSING: begin
							rel_c = 1'b1;
							st = item.session_up ? ST_CLOSED : ST_DOWN;
						end
						default: ;
					endcase
				end
			end
			CMD_CONNECTED: begin
				st = ST_CONNECTED;
				tmr = TIMER_BITS'(cfg.response_timeout);
				send_c = 1'b1;
			end
			CMD_RECEIVE: begin
				count_nxt = COUNT_BITS'(cnt_ext + take_ext);
				acc_c = take_ext[15:0];
				full_c = rx_over;
				if (rx_over || item.response_complete) begin
					st = close_active(st);
				end
			end
			CMD_ERROR: begin
				if (st == ST_CONNECTING || st == ST_CONNECTED) begin
					err_flag_nxt = 1'b1;
					err_code_nxt = item.error_code;
				end
				st = close_active(st);
			end
			CMD_START: begin
				if (st == ST_CLOSED) begin
					st = ST_IDLE;
					err_flag_nxt = 1'b0;
					err_code_nxt = '0;
				end
			end
			CMD_STOP: begin
				st = close_active(st);
			end
			default: ;	// unknown command: no change
		endcase

		state_nxt = st;
		timer_nxt = tmr;

		result.client_state = st;
		result.open_connection = open_c;
		result.send_request = send_c;
		result.release_connection = rel_c;
		result.accepted_bytes = acc_c;
		result.buffer_full = full_c;
		result.timeout_kind = tk_c;
		result.error_valid = err_flag_nxt;
		result.error_held = err_code_nxt;
	end

endmodule

// File: rtl/http_client_lifecycle_fsm.sv
// Client lifecycle supervisor: one event in, one result out.
// The item passes the input register, then the result register.
// Throughput: one event per cycle if not stalled; lifecycle state updates in the result stage.
// Reset (arst_n low): state session-down, counters and error record zero, registers at defaults.
// Depends on hclf_pkg, hclf_cfg_regs and hclf_next.
module http_client_lifecycle_fsm
	import hclf_pkg::*;
#(
	parameter int TIMER_BITS = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_item,
	input  logic cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t cfg;

	hclf_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// input stage
	logic valid_s1;
	in_item_t item_s1;
	logic advance;
	logic fire;
	logic out_valid_q;
	out_item_t out_item_q;

	assign advance = !out_valid_q || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// lifecycle state
	lc_state_t state_q, state_nxt;
	logic [TIMER_BITS-1:0] timer_q, timer_nxt;
	logic [COUNT_BITS-1:0] count_q, count_nxt;
	logic err_flag_q, err_flag_nxt;
	logic signed [7:0] err_code_q, err_code_nxt;
	out_item_t result;

	hclf_next #(
		.TIMER_BITS(TIMER_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_next (
		.cfg(cfg),
		.item(item_s1),
		.state_cur(state_q),
		.timer_cur(timer_q),
		.count_cur(count_q),
		.err_flag_cur(err_flag_q),
		.err_code_cur(err_code_q),
		.state_nxt(state_nxt),
		.timer_nxt(timer_nxt),
		.count_nxt(count_nxt),
		.err_flag_nxt(err_flag_nxt),
		.err_code_nxt(err_code_nxt),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DOWN;
			timer_q <= '0;
			count_q <= '0;
			err_flag_q <= 1'b0;
			err_code_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
			timer_q <= timer_nxt;
			count_q <= count_nxt;
			err_flag_q <= err_flag_nxt;
			err_code_q <= err_code_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	// the byte count only grows between resets
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q >= $past(count_q))
		else $error("response byte count decreased");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed item produced no result");

	a_open_release_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_item_q.open_connection && out_item_q.release_connection))
		else $error("open and release in the same result");

	a_timeout_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.timeout_kind != TMO_NONE)
			|-> out_item_q.release_connection)
		else $error("timeout without release");

endmodule

// File: sim/http_client_lifecycle_fsm_tb.sv
// Testbench of the client lifecycle supervisor: directed event walks, then random events
// steered by the predicted state, under random idling, checked item by item.
// Depends on hclf_pkg and the http_client_lifecycle_fsm RTL.
module http_client_lifecycle_fsm_tb;
	import hclf_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// predicted client state and register copies
	lc_state_t m_state = ST_DOWN;
	logic [15:0] m_timer = '0;
	logic [15:0] m_bytes = '0;
	logic m_err_valid = 1'b0;
	logic signed [7:0] m_err_code = '0;
	cfg_t m_cfg = '{RST_CONNECT_TIMEOUT, RST_RESPONSE_TIMEOUT, RST_RESPONSE_LIMIT, RST_AUTOSTART};

	out_item_t pending_results[$];
	int bad_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	http_client_lifecycle_fsm u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Advance the predicted client by one event and return its result.
	function automatic out_item_t advance_client(input in_item_t ev);
		out_item_t r;
		logic live;
		logic shut;
		logic [15:0] take;
		r = '0;
		shut = 1'b0;
		case (ev.command)
			CMD_TICK: begin
				live = 1'b1;
				if (ev.session_up) begin
					if (m_state == ST_DOWN)
						m_state = m_cfg.autostart ? ST_IDLE : ST_CLOSED;
				end else if (m_state == ST_DOWN) begin
					live = 1'b0;
				end else if (m_state == ST_IDLE || m_state == ST_CLOSED) begin
					m_state = ST_DOWN;
					live = 1'b0;
				end else if (m_state == ST_CONNECTING || m_state == ST_CONNECTED) begin
					m_state = ST_CLOSING;
				end
				if (live) begin
					if (ev.teardown) begin
						if (m_state == ST_IDLE)
							m_state = ST_CLOSED;
						else if (m_state == ST_CONNECTING || m_state == ST_CONNECTED)
							m_state = ST_CLOSING;
					end
					case (m_state)
						ST_IDLE: begin
							r.open_connection = 1'b1;
							if (ev.connect_ok) begin
								m_state = ST_CONNECTING;
								m_timer = m_cfg.connect_timeout;
							end
						end
						ST_CONNECTING, ST_CONNECTED: begin
							if (m_timer != 0)
								m_timer = m_timer - 16'd1;
							if (m_timer == 0) begin
								r.release_connection = 1'b1;
								if (m_state == ST_CONNECTING) begin
									r.timeout_kind = TMO_CONNECT;
									m_state = ST_IDLE;
								end else begin
									r.timeout_kind = TMO_RESPONSE;
									m_state = ev.session_up ? ST_CLOSED : ST_DOWN;
								end
							end
						end
						ST_CLOSING: begin
							r.release_connection = 1'b1;
							m_state = ev.session_up ? ST_CLOSED : ST_DOWN;
						end
						default: ;
					endcase
				end
			end
			CMD_CONNECTED: begin
				m_state = ST_CONNECTED;
				m_timer = m_cfg.response_timeout;
				r.send_request = 1'b1;
			end
			CMD_RECEIVE: begin
				take = ev.rx_len;
				// truncate at the limit; a count already past the limit takes nothing
				if (17'(m_bytes) + 17'(ev.rx_len) > 17'(m_cfg.response_limit)) begin
					take = (m_cfg.response_limit > m_bytes) ? m_cfg.response_limit - m_bytes : 16'd0;
					r.buffer_full = 1'b1;
					shut = 1'b1;
				end
				m_bytes = m_bytes + take;
				r.accepted_bytes = take;
				if (ev.response_complete)
					shut = 1'b1;
				if (shut && (m_state == ST_CONNECTING || m_state == ST_CONNECTED))
					m_state = ST_CLOSING;
			end
			CMD_ERROR: begin
				if (m_state == ST_CONNECTING || m_state == ST_CONNECTED) begin
					m_err_valid = 1'b1;
					m_err_code = ev.error_code;
					m_state = ST_CLOSING;
				end
			end
			CMD_START: begin
				if (m_state == ST_CLOSED) begin
					m_state = ST_IDLE;
					m_err_valid = 1'b0;
					m_err_code = '0;
				end
			end
			CMD_STOP: begin
				if (m_state == ST_CONNECTING || m_state == ST_CONNECTED)
					m_state = ST_CLOSING;
			end
			default: ;
		endcase
		r.client_state = m_state;
		r.error_valid = m_err_valid;
		r.error_held = m_err_code;
		return r;
	endfunction

	function automatic in_item_t mk_event(input logic [2:0] cmd, input logic sess,
			input logic tear, input logic ok, input logic [15:0] len, input logic done,
			input logic signed [7:0] code);
		in_item_t ev;
		ev.command = cmd;
		ev.session_up = sess;
		ev.teardown = tear;
		ev.connect_ok = ok;
		ev.rx_len = len;
		ev.response_complete = done;
		ev.error_code = code;
		return ev;
	endfunction

	// Mostly events that fit the predicted state, some pure noise.
	function automatic in_item_t next_event();
		in_item_t ev;
		int pick;
		ev.session_up = ($urandom_range(0, 19) != 0);
		ev.teardown = ($urandom_range(0, 24) == 0);
		ev.connect_ok = ($urandom_range(0, 4) != 0);
		ev.response_complete = ($urandom_range(0, 5) == 0);
		ev.rx_len = ($urandom_range(0, 39) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		ev.error_code = 8'($urandom);
		pick = $urandom_range(0, 9);
		case (m_state)
			ST_DOWN: ev.command = (pick < 8) ? CMD_TICK : (pick == 8) ? CMD_CONNECTED : CMD_START;
			ST_IDLE: ev.command = (pick < 7) ? CMD_TICK : (pick == 7) ? CMD_CONNECTED :
				(pick == 8) ? CMD_START : CMD_STOP;
			ST_CONNECTING: ev.command = (pick < 5) ? CMD_CONNECTED : (pick < 8) ? CMD_TICK :
				(pick == 8) ? CMD_ERROR : CMD_STOP;
			ST_CONNECTED: ev.command = (pick < 5) ? CMD_RECEIVE : (pick < 8) ? CMD_TICK :
				(pick == 8) ? CMD_ERROR : CMD_STOP;
			ST_CLOSING: ev.command = (pick < 7) ? CMD_TICK : CMD_RECEIVE;
			default: ev.command = (pick < 6) ? CMD_START : CMD_TICK;
		endcase
		if ($urandom_range(0, 9) == 0) begin
			ev = in_item_t'($bits(in_item_t)'($urandom));
			ev.command = 3'($urandom_range(0, 7));
		end
		return ev;
	endfunction

	task automatic send_item(input in_item_t ev);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= ev;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(advance_client(ev));
	endtask

	// Drop valid and hold until every pending result is back.
	task automatic wait_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CONNECT_TIMEOUT: m_cfg.connect_timeout = value;
			CFG_RESPONSE_TIMEOUT: m_cfg.response_timeout = value;
			CFG_RESPONSE_LIMIT: m_cfg.response_limit = value;
			CFG_AUTOSTART: m_cfg.autostart = value[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic note_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			bad_count++;
			if (bad_count <= 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			bad_count++;
			if (bad_count <= 10)
				$display("result with nothing pending: %h", got);
		end else begin
			want = pending_results.pop_front();
			note_field("client_state", want.client_state, got.client_state);
			note_field("open_connection", want.open_connection, got.open_connection);
			note_field("send_request", want.send_request, got.send_request);
			note_field("release_connection", want.release_connection, got.release_connection);
			note_field("accepted_bytes", want.accepted_bytes, got.accepted_bytes);
			note_field("buffer_full", want.buffer_full, got.buffer_full);
			note_field("timeout_kind", want.timeout_kind, got.timeout_kind);
			note_field("error_valid", want.error_valid, got.error_valid);
			note_field("error_held", want.error_held, got.error_held);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
			if (out_valid && !out_stall)
				check_result(out_item);
		end
	end

	// Stall the result side in bursts of random length.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_lifecycle_walk();
		send_item(mk_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_UNUSED_LO, 1'b1, 1'b1, 1'b1, 16'hffff, 1'b1, -8'sd1));
		send_item(mk_event(CMD_UNUSED_HI, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		// session comes up, first connect attempt fails
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b1, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_ERROR, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sh80));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_START, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b1, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_CONNECTED, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_RECEIVE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_RECEIVE, 1'b0, 1'b0, 1'b0, 16'hffff, 1'b0, 8'sd0));
		// count sits at the limit: nothing more is taken
		send_item(mk_event(CMD_RECEIVE, 1'b0, 1'b0, 1'b0, 16'd10, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_CONNECTED, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_ERROR, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd127));
		send_item(mk_event(CMD_STOP, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_START, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b1, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_CONNECTED, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_RECEIVE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1, 8'sd0));
		send_item(mk_event(CMD_ERROR, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd55));
		wait_results();
	endtask

	task automatic test_timeouts();
		set_reg(CFG_CONNECT_TIMEOUT, 16'd1);
		set_reg(CFG_RESPONSE_TIMEOUT, 16'd1);
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_START, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b1, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b1, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_CONNECTED, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		wait_results();
		// a zero timeout expires on the first tick
		set_reg(CFG_CONNECT_TIMEOUT, 16'd0);
		send_item(mk_event(CMD_START, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b1, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		wait_results();
		set_reg(CFG_AUTOSTART, 16'd0);
		set_reg(CFG_CONNECT_TIMEOUT, 16'hffff);
		set_reg(CFG_RESPONSE_TIMEOUT, 16'hffff);
		set_reg(CFG_RESPONSE_LIMIT, 16'd1);
		send_item(mk_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_CONNECTED, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		send_item(mk_event(CMD_RECEIVE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'sd0));
		wait_results();
	endtask

	task automatic run_random(input int count, input int gap, input int stall);
		int k;
		for (k = 0; k < count; k++) begin
			// each stretch runs with or without idling, picked at random
			if (k % 64 == 0) begin
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : gap;
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : stall;
			end
			send_item(next_event());
		end
		wait_results();
	endtask

	task automatic test_pause_for_results();
		int k;
		for (k = 0; k < 4; k++) begin
			gap_pct = 25;
			stall_pct = 25;
			repeat (30) send_item(next_event());
			wait_results();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lifecycle_walk();
		test_timeouts();
		set_reg(CFG_AUTOSTART, 16'd1);
		set_reg(CFG_CONNECT_TIMEOUT, 16'($urandom_range(1, 6)));
		set_reg(CFG_RESPONSE_TIMEOUT, 16'($urandom_range(1, 8)));
		set_reg(CFG_RESPONSE_LIMIT, 16'hffff);
		run_random(600, 30, 30);
		set_reg(CFG_AUTOSTART, 16'd0);
		set_reg(CFG_RESPONSE_LIMIT, 16'($urandom_range(100, 40000)));
		test_pause_for_results();
		set_reg(CFG_CONNECT_TIMEOUT, 16'hffff);
		set_reg(CFG_RESPONSE_TIMEOUT, 16'hffff);
		set_reg(CFG_RESPONSE_LIMIT, 16'd1);
		run_random(400, 20, 40);
		set_reg(CFG_AUTOSTART, 16'd1);
		set_reg(CFG_CONNECT_TIMEOUT, 16'd2);
		set_reg(CFG_RESPONSE_TIMEOUT, 16'd3);
		set_reg(CFG_RESPONSE_LIMIT, 16'hffff);
		run_random(600, 0, 0);
		repeat (8) @(posedge clk);
		if (bad_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: http_client_lifecycle_fsm.f
rtl/hclf_pkg.sv
rtl/hclf_cfg_regs.sv
rtl/hclf_next.sv
rtl/http_client_lifecycle_fsm.sv
sim/http_client_lifecycle_fsm_tb.sv
